// ===== rtl/core/lcs_pkg.sv =====
// ============================================================================
// lcs_pkg: shared types and constants of the lens carousel sequencer
// Beat payloads, configuration layout, status and motion codes.
// ============================================================================
package lcs_pkg;

    localparam int LENSES      = 7;
    localparam int LENS_IDX_W  = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int STATUS_LSB  = 14;

    localparam logic [LENS_IDX_W-1:0] NO_LENS = 3'd7;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENT = 2'd3;

    // Reset values of the configuration registers
    localparam logic [7:0]  SETTLE_RESET  = 8'd5;
    localparam logic [15:0] TIMEOUT_RESET = 16'd30000;
    localparam logic [9:0]  RETRY_RESET   = 10'd100;

    // Process status codes
    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;

    // Motion phase codes as reported
    localparam logic [1:0] MPH_IDLE    = 2'd0;
    localparam logic [1:0] MPH_SELECT  = 2'd1;
    localparam logic [1:0] MPH_INSERT  = 2'd2;
    localparam logic [1:0] MPH_RETRACT = 2'd3;

    // Item function codes
    localparam logic FUNC_TICK    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef struct packed {
        logic              func;
        logic [LENSES-1:0] request_mask;
        logic [2:0]        station;
        logic [LENSES-1:0] select_switches;
        logic [LENSES-1:0] in_switches;
        logic [LENSES-1:0] out_switches;
    } lcs_item_t;

    typedef struct packed {
        logic                  stepper_run;
        logic                  dc_run;
        logic                  dc_into_beam;
        logic [1:0]            process_status;
        logic [1:0]            motion_phase;
        logic [LENS_IDX_W-1:0] moving_lens;
        logic [LENS_IDX_W-1:0] confirmed_position;
        logic [LENSES-1:0]     applied_mask;
        logic [15:0]           status_word;
        logic [15:0]           done_count;
        logic [15:0]           failed_count;
    } lcs_result_t;

    typedef struct packed {
        logic [7:0]  settle_ticks;
        logic [15:0] timeout_ticks;
        logic [9:0]  retry_ticks;
        logic        mechanism_present;
    } lcs_cfg_t;

    // Bit of a lens mask; lens numbers at or above LENSES read as zero
    function automatic logic bit_of(input logic [LENSES-1:0] mask,
                                    input logic [LENS_IDX_W-1:0] idx);
        logic b;
        b = 1'b0;
        if (idx < LENS_IDX_W'(LENSES))
        begin
            b = mask[idx];
        end
        return b;
    endfunction

    // Pending lens nearest ahead of the station in forward travel, or NO_LENS
    function automatic logic [LENS_IDX_W-1:0] pick_lens(
        input logic [LENSES-1:0]     pending,
        input logic [LENS_IDX_W-1:0] station);
        logic [LENS_IDX_W-1:0] st;
        logic [LENS_IDX_W:0]   idx;
        logic [LENS_IDX_W-1:0] best;
        st = station;
        if (st >= LENS_IDX_W'(LENSES))
        begin
            st = st - LENS_IDX_W'(LENSES);
        end
        best = NO_LENS;
        // Walk backward so the smallest forward distance wins
        for (int k = LENSES - 1; k >= 0; k--)
        begin
            idx = {1'b0, st} + (LENS_IDX_W+1)'(k);
            if (idx >= (LENS_IDX_W+1)'(LENSES))
            begin
                idx = idx - (LENS_IDX_W+1)'(LENSES);
            end
            if (pending[idx[LENS_IDX_W-1:0]])
            begin
                best = idx[LENS_IDX_W-1:0];
            end
        end
        return best;
    endfunction

endpackage

// ===== rtl/core/lcs_if.sv =====
// ============================================================================
// lcs_if: valid/ready channels of the lens carousel sequencer
// One channel for incoming item beats, one for result beats.
// ============================================================================
interface lcs_item_if;
    import lcs_pkg::*;

    logic      valid;
    logic      ready;
    lcs_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lcs_result_if;
    import lcs_pkg::*;

    logic        valid;
    logic        ready;
    lcs_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/lcs_core.sv =====
// ============================================================================
// lcs_core: carousel sequencing state and its one-beat update
// Holds the sweep state; each enabled cycle applies one item beat.
// ============================================================================
module lcs_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  lcs_pkg::lcs_item_t  item,
    input  lcs_pkg::lcs_cfg_t   cfg,
    output lcs_pkg::lcs_result_t result
);
    import lcs_pkg::*;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_SELECT     = 3'd1;
    localparam logic [2:0] PH_SEL_SETTLE = 3'd2;
    localparam logic [2:0] PH_DC_SETTLE  = 3'd3;
    localparam logic [2:0] PH_DC_WAIT    = 3'd4;

    localparam logic [1:0] C_UNKNOWN = 2'd0;
    localparam logic [1:0] C_IN      = 2'd1;
    localparam logic [1:0] C_OUT     = 2'd2;
    localparam logic [1:0] C_MOVING  = 2'd3;

    logic [LENSES-1:0]     wanted_reg,    wanted_next;
    logic [LENSES-1:0]     committed_reg, committed_next;
    logic [LENSES-1:0]     goal_reg,      goal_next;
    logic [1:0]            cond_reg [LENSES];
    logic [1:0]            cond_next [LENSES];
    logic [2:0]            phase_reg,     phase_next;
    logic [LENS_IDX_W-1:0] active_reg,    active_next;
    logic [15:0]           wait_reg,      wait_next;
    logic [1:0]            status_reg,    status_next;
    logic [15:0]           ok_reg,        ok_next;
    logic [15:0]           bad_reg,       bad_next;
    logic [LENS_IDX_W-1:0] confirmed_reg, confirmed_next;
    logic [9:0]            retry_reg,     retry_next;

    logic                  do_sweep;
    logic                  do_pick;
    logic                  into;
    logic                  dc_on;
    logic                  step_on;
    logic [LENS_IDX_W-1:0] a;
    logic [LENS_IDX_W-1:0] nxt;
    logic [15:0]           word;

    always_comb
    begin
        wanted_next    = wanted_reg;
        committed_next = committed_reg;
        goal_next      = goal_reg;
        cond_next      = cond_reg;
        phase_next     = phase_reg;
        active_next    = active_reg;
        wait_next      = wait_reg;
        status_next    = status_reg;
        ok_next        = ok_reg;
        bad_next       = bad_reg;
        confirmed_next = confirmed_reg;
        retry_next     = retry_reg;
        do_sweep       = 1'b0;
        do_pick        = 1'b0;
        a              = active_reg;
        into           = bit_of(goal_reg, a);
        nxt            = NO_LENS;

        if (item.func == FUNC_REQUEST)
        begin
            wanted_next = item.request_mask;
        end

        if (!cfg.mechanism_present)
        begin
            // Drop the move without counting it
            if (phase_reg != PH_IDLE && a < LENS_IDX_W'(LENSES))
            begin
                cond_next[a] = C_UNKNOWN;
            end
            phase_next  = PH_IDLE;
            active_next = NO_LENS;
            wait_next   = '0;
            status_next = ST_FAULT;
        end
        else if (item.func == FUNC_REQUEST)
        begin
            do_sweep = (phase_reg == PH_IDLE);
        end
        else
        begin
            unique case (phase_reg)
                PH_SELECT:
                begin
                    if (bit_of(item.select_switches, a))
                    begin
                        confirmed_next = a;
                        phase_next     = PH_SEL_SETTLE;
                        wait_next      = '0;
                    end
                    else if (wait_reg >= cfg.timeout_ticks)
                    begin
                        if (a < LENS_IDX_W'(LENSES))
                        begin
                            cond_next[a] = C_UNKNOWN;
                        end
                        phase_next  = PH_IDLE;
                        active_next = NO_LENS;
                        wait_next   = '0;
                        bad_next    = bad_reg + 16'd1;
                        status_next = ST_FAULT;
                        retry_next  = '0;
                    end
                    else
                    begin
                        wait_next = wait_reg + 16'd1;
                    end
                end
                PH_SEL_SETTLE, PH_DC_SETTLE:
                begin
                    wait_next = wait_reg + 16'd1;
                    if (wait_next >= {8'd0, cfg.settle_ticks})
                    begin
                        phase_next = (phase_reg == PH_SEL_SETTLE) ? PH_DC_SETTLE
                                                                  : PH_DC_WAIT;
                        wait_next  = '0;
                    end
                end
                PH_DC_WAIT:
                begin
                    if (bit_of(into ? item.in_switches : item.out_switches, a))
                    begin
                        if (a < LENS_IDX_W'(LENSES))
                        begin
                            cond_next[a]      = into ? C_IN : C_OUT;
                            committed_next[a] = into;
                        end
                        ok_next     = ok_reg + 16'd1;
                        phase_next  = PH_IDLE;
                        active_next = NO_LENS;
                        do_pick     = 1'b1;
                    end
                    else if (wait_reg >= cfg.timeout_ticks)
                    begin
                        if (a < LENS_IDX_W'(LENSES))
                        begin
                            cond_next[a] = C_UNKNOWN;
                        end
                        phase_next  = PH_IDLE;
                        active_next = NO_LENS;
                        wait_next   = '0;
                        bad_next    = bad_reg + 16'd1;
                        status_next = ST_FAULT;
                        retry_next  = '0;
                    end
                    else
                    begin
                        wait_next = wait_reg + 16'd1;
                    end
                end
                default:
                begin
                    if (status_reg == ST_FAULT)
                    begin
                        retry_next = retry_reg + 10'd1;
                        do_sweep   = (retry_next >= cfg.retry_ticks);
                    end
                    else
                    begin
                        do_sweep = (wanted_reg != committed_reg);
                    end
                end
            endcase
        end

        if (do_sweep)
        begin
            goal_next  = wanted_next;
            retry_next = '0;
            do_pick    = 1'b1;
        end

        if (do_pick)
        begin
            nxt = pick_lens(goal_next ^ committed_next, item.station);
            if (nxt == NO_LENS)
            begin
                status_next = ST_READY;
                phase_next  = PH_IDLE;
                active_next = NO_LENS;
            end
            else
            begin
                status_next    = ST_BUSY;
                active_next    = nxt;
                cond_next[nxt] = C_MOVING;
                phase_next     = PH_SELECT;
                wait_next      = '0;
            end
        end
    end

    // Result fields follow the state after this beat
    always_comb
    begin
        step_on = (phase_next == PH_SELECT) || (phase_next == PH_SEL_SETTLE);
        dc_on   = (phase_next == PH_DC_SETTLE) || (phase_next == PH_DC_WAIT);
        word    = '0;
        for (int i = 0; i < LENSES; i++)
        begin
            word[2*i +: 2] = cond_next[i];
        end
        word[STATUS_LSB +: 2] = status_next;

        result.stepper_run        = step_on;
        result.dc_run             = dc_on;
        result.dc_into_beam       = dc_on & bit_of(goal_next, active_next);
        result.process_status     = status_next;
        result.motion_phase       = step_on ? MPH_SELECT
                                  : (dc_on ? (bit_of(goal_next, active_next) ? MPH_INSERT
                                                                             : MPH_RETRACT)
                                           : MPH_IDLE);
        result.moving_lens        = active_next;
        result.confirmed_position = confirmed_reg == confirmed_next ? confirmed_reg
                                                                    : confirmed_next;
        result.applied_mask       = committed_next;
        result.status_word        = word;
        result.done_count         = ok_next;
        result.failed_count       = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg    <= '0;
            committed_reg <= '0;
            goal_reg      <= '0;
            for (int i = 0; i < LENSES; i++)
            begin
                cond_reg[i] <= C_UNKNOWN;
            end
            phase_reg     <= PH_IDLE;
            active_reg    <= NO_LENS;
            wait_reg      <= '0;
            status_reg    <= ST_READY;
            ok_reg        <= '0;
            bad_reg       <= '0;
            confirmed_reg <= NO_LENS;
            retry_reg     <= '0;
        end
        else if (step_en)
        begin
            wanted_reg    <= wanted_next;
            committed_reg <= committed_next;
            goal_reg      <= goal_next;
            cond_reg      <= cond_next;
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            wait_reg      <= wait_next;
            status_reg    <= status_next;
            ok_reg        <= ok_next;
            bad_reg       <= bad_next;
            confirmed_reg <= confirmed_next;
            retry_reg     <= retry_next;
        end
    end

endmodule

// ===== rtl/core/lens_carousel_sequencer.sv =====
// ============================================================================
// lens_carousel_sequencer: seven-lens carousel move sequencer
// Steps a carousel and lens DC motor toward a requested in/out lens mask.
// ============================================================================
//
// Usage
//   item   : sink channel. Each beat is either a 1 ms tick (func = 0) carrying
//            the station index and the select/in/out limit switch levels, or
//            a new lens request (func = 1) carrying the desired mask.
//   result : source channel. Exactly one beat leaves per item beat, in order,
//            holding motor drive, phase, lens and status after that item.
//   cfg_*  : plain write port for settle, timeout, retry and presence
//            registers; write only while no beat is in flight.
//   Path: the input register takes the beat, then the sequencing update
//   loads the result register from it. Throughput is one beat per cycle
//   while the result receiver keeps result.ready high; the only loop is
//   the registered state update inside lcs_core.
//   Reset clears all sequencing state (status ready, no lens, all lens
//   conditions unknown) and loads the default register values.
//   When the result receiver stalls, the result register holds its beat and
//   the input register holds one more; after that item.ready drops.
//
module lens_carousel_sequencer
(
    input  logic                                clk,
    input  logic                                rst_n,
    lcs_item_if.sink                            item,
    lcs_result_if.source                        result,
    input  logic                                cfg_wr_en,
    input  logic [lcs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lcs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lcs_pkg::*;

    lcs_cfg_t    cfg_reg;
    logic        in_valid_reg;
    lcs_item_t   in_data_reg;
    logic        out_valid_reg;
    lcs_result_t out_data_reg;
    lcs_result_t step_result;
    logic        advance;

    // Move the held beat forward when the result register is free or drains
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks      <= SETTLE_RESET;
            cfg_reg.timeout_ticks     <= TIMEOUT_RESET;
            cfg_reg.retry_ticks       <= RETRY_RESET;
            cfg_reg.mechanism_present <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SETTLE:  cfg_reg.settle_ticks      <= cfg_data[7:0];
                CFG_TIMEOUT: cfg_reg.timeout_ticks     <= cfg_data[15:0];
                CFG_RETRY:   cfg_reg.retry_ticks       <= cfg_data[9:0];
                CFG_PRESENT: cfg_reg.mechanism_present <= cfg_data[0];
                default:     cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // Input register: take a new beat whenever the slot is empty or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_data_reg <= item.data;
        end
    end

    // Sequencing state and its update
    lcs_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    // Result register: hold the beat until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= step_result;
        end
    end

endmodule

// ===== rtl/core/lcs_checker.sv =====
// ============================================================================
// lcs_checker: port-level checks of the lens carousel sequencer
// Motor interlock and status consistency on result beats.
// ============================================================================
module lcs_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input lcs_pkg::lcs_result_t out_data
);
    import lcs_pkg::*;

    // Stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Never drive stepper and DC motor together
    a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.stepper_run && out_data.dc_run))
        else $error("stepper and DC motor driven together");

    // Direction only set while the DC motor runs
    a_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.dc_into_beam |-> out_data.dc_run)
        else $error("DC direction set with motor off");

    // Idle phase goes with no moving lens, and the reverse
    a_idle_lens: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.motion_phase == MPH_IDLE) ==
                       (out_data.moving_lens == NO_LENS)))
        else $error("moving lens disagrees with motion phase");

    // Busy status only while a lens moves; status copy in the word matches
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status_word[STATUS_LSB +: 2] == out_data.process_status)
                   && (out_data.motion_phase != MPH_IDLE
                       || out_data.process_status != ST_BUSY))
        else $error("process status inconsistent with motion");

endmodule

bind lens_carousel_sequencer lcs_checker u_lcs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
